/* src/sse_pkg.sv */
package sse_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int DATA_W      = 32;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] word_t;

endpackage

/* src/selection_sort_engine.sv */
// Selection sort engine: collects a set of signed 32-bit values, sorts them ascending, streams them out.
// Load: one value per cycle while in_tready is high; the item with in_tlast closes the set.
// Sort: pass k over N stored values streams N-k reads through the single read port, one
//   compare per cycle, then emits the minimum and writes back once the output register is free.
// Reset (rst_n low, synchronous) clears the control state and counters; the value store is not cleared.
module selection_sort_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tlast,   // last_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] sorted_value
  output logic        out_tlast,  // last_out
  output logic [0:0]  out_tuser   // [0] dropped
);

  typedef enum logic [1:0] {
    S_LOAD,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t                state_r;
  sse_pkg::cnt_t         cnt_r;       // entries stored in the current set
  logic                  ovf_r;       // a value of this set was dropped
  sse_pkg::cnt_t         pos_r;       // position being filled by the current pass
  sse_pkg::cnt_t         rd_ptr_r;    // next entry to read in this pass
  sse_pkg::cnt_t         pipe_idx_r;  // entry whose data sits in rd_data_r
  logic                  pipe_vld_r;
  sse_pkg::word_t        rd_data_r;
  sse_pkg::word_t        min_r;
  sse_pkg::word_t        min_nxt;
  sse_pkg::cnt_t         best_r;
  sse_pkg::cnt_t         best_nxt;
  sse_pkg::word_t        pos_val_r;   // original value at pos, moved into the winner's slot
  sse_pkg::word_t        pos_val_nxt;

  logic                  out_tvalid_r;
  sse_pkg::word_t        out_tdata_r;
  logic                  out_tlast_r;
  logic                  out_tuser_r;

  sse_pkg::word_t        mem [sse_pkg::MAX_ENTRIES];

  logic                  in_acc;
  logic                  has_room;
  logic                  out_free;
  logic                  emit_go;
  logic                  rd_issue;
  logic                  first_hit;
  logic                  take;
  logic                  scan_done;
  logic                  last_pass;
  logic                  wr_en;
  sse_pkg::addr_t        wr_addr;
  sse_pkg::word_t        wr_data;

  assign in_tready  = (state_r == S_LOAD);
  assign in_acc     = in_tvalid && in_tready;
  assign has_room   = cnt_r < sse_pkg::CNT_W'(sse_pkg::MAX_ENTRIES);
  // Output register can take a new request when empty or being drained this cycle.
  assign out_free   = !out_tvalid_r || out_tready;
  assign emit_go    = (state_r == S_EMIT) && out_free;
  assign rd_issue   = (state_r == S_SCAN) && (rd_ptr_r < cnt_r);
  assign last_pass  = (pos_r == cnt_r - sse_pkg::CNT_W'(1));

  // Running minimum over the pass; strict less-than keeps the first of equal values.
  always_comb begin
    first_hit   = (pipe_idx_r == pos_r);
    take        = first_hit || ($signed(rd_data_r) < $signed(min_r));
    min_nxt     = min_r;
    best_nxt    = best_r;
    pos_val_nxt = pos_val_r;
    if (pipe_vld_r) begin
      if (take) begin
        min_nxt  = rd_data_r;
        best_nxt = pipe_idx_r;
      end
      if (first_hit) begin
        pos_val_nxt = rd_data_r;
      end
    end
  end

  assign scan_done = pipe_vld_r && (pipe_idx_r == cnt_r - sse_pkg::CNT_W'(1));

  // One write port: loading stores the new value, emitting moves the pos value into the
  // winner's slot (the winner itself leaves through the output).
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_r[sse_pkg::ADDR_W-1:0];
    wr_data = in_tdata;
    if (state_r == S_LOAD) begin
      wr_en = in_acc && has_room;
    end else if (emit_go) begin
      wr_en   = 1'b1;
      wr_addr = best_r[sse_pkg::ADDR_W-1:0];
      wr_data = pos_val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_ptr_r[sse_pkg::ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      cnt_r        <= '0;
      ovf_r        <= 1'b0;
      pos_r        <= '0;
      rd_ptr_r     <= '0;
      pipe_idx_r   <= '0;
      pipe_vld_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      // Load a new request on emit, hold a waiting one, drop valid once taken.
      out_tvalid_r <= emit_go || (out_tvalid_r && !out_tready);
      pipe_vld_r <= rd_issue;
      pipe_idx_r <= rd_ptr_r;
      unique case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (has_room) begin
              cnt_r <= cnt_r + sse_pkg::CNT_W'(1);
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_tlast) begin
              pos_r    <= '0;
              rd_ptr_r <= '0;
              state_r  <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rd_issue) begin
            rd_ptr_r <= rd_ptr_r + sse_pkg::CNT_W'(1);
          end
          min_r     <= min_nxt;
          best_r    <= best_nxt;
          pos_val_r <= pos_val_nxt;
          if (scan_done) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_tdata_r  <= min_r;
            out_tlast_r  <= last_pass;
            out_tuser_r  <= ovf_r;
            if (last_pass) begin
              // Set done: drop counters and reopen the input.
              cnt_r   <= '0;
              ovf_r   <= 1'b0;
              state_r <= S_LOAD;
            end else begin
              pos_r    <= pos_r + sse_pkg::CNT_W'(1);
              rd_ptr_r <= pos_r + sse_pkg::CNT_W'(1);
              state_r  <= S_SCAN;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= sse_pkg::CNT_W'(sse_pkg::MAX_ENTRIES))
    else $error("entry count beyond capacity");

  a_pos_in_set: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_EMIT) |-> (pos_r < cnt_r))
    else $error("sort position outside the stored set");

  a_best_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (best_r >= pos_r && best_r < cnt_r))
    else $error("write-back slot outside the unsorted part");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && last_pass) |=> (state_r == S_LOAD && cnt_r == '0 && out_tlast))
    else $error("set end did not reopen the input");

endmodule

/* verif/tb_selection_sort_engine.sv */
`timescale 1ns / 100ps

module tb_selection_sort_engine;

  // Quiet cycles (no request accepted on either side) before the run is called hung.
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 100;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    sse_pkg::word_t value;
    logic           last;
    logic           dropped;
  } sorted_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic [0:0]  out_tuser;

  int send_idle_pct;
  int recv_idle_pct;
  int mismatch_count;
  int stall_cycles;

  // Values of the set being loaded, and whether any was discarded.
  sse_pkg::word_t pending_set[$];
  bit             pending_overflow;
  sorted_result_t sorted_expect[$];

  selection_sort_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Mirror one accepted request: store or drop the value; on the closing item sort the
  // set and queue its ascending results.
  function automatic void predict_request(input sse_pkg::word_t value, input bit last);
    sse_pkg::word_t held[sse_pkg::MAX_ENTRIES];
    sse_pkg::word_t swap_tmp;
    int    n;
    int    best;
    if (pending_set.size() < sse_pkg::MAX_ENTRIES) begin
      pending_set.push_back(value);
    end else begin
      pending_overflow = 1'b1;
    end
    if (last) begin
      n = pending_set.size();
      for (int k = 0; k < n; k++) begin
        held[k] = pending_set[k];
      end
      for (int pos = 0; pos + 1 < n; pos++) begin
        best = pos;
        for (int scan = pos + 1; scan < n; scan++) begin
          if ($signed(held[scan]) < $signed(held[best])) begin
            best = scan;
          end
        end
        swap_tmp   = held[pos];
        held[pos]  = held[best];
        held[best] = swap_tmp;
      end
      for (int k = 0; k < n; k++) begin
        sorted_expect.push_back('{value: held[k], last: (k == n - 1),
                                  dropped: pending_overflow});
      end
      pending_set.delete();
      pending_overflow = 1'b0;
    end
  endfunction

  // Mix full-range values, extremes and a narrow band that forces ties.
  function automatic sse_pkg::word_t pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 55) begin
      return sse_pkg::word_t'($urandom);
    end else if (sel < 70) begin
      case ($urandom_range(3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end else begin
      return sse_pkg::word_t'(int'($urandom_range(8)) - 4);
    end
  endfunction

  // Send one request: idle at random, then hold valid until the block takes it.
  task automatic send_request(input sse_pkg::word_t value, input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    predict_request(value, last);
  endtask

  // Drop valid and hold off until every queued result has drained.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sorted_expect.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic send_set(input sse_pkg::word_t values[$]);
    for (int k = 0; k < values.size(); k++) begin
      send_request(values[k], k == values.size() - 1);
    end
  endtask

  task automatic test_directed_values();
    sse_pkg::word_t vals[$];
    send_set('{32'h7fff_ffff});
    send_set('{32'h8000_0000});
    wait_drained();
    send_set('{32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0000, 32'h7fff_ffff});
    // ties: equal values must still come out in order
    send_set('{32'd5, 32'hffff_fffb, 32'd5, 32'd5});
    // descending input, worst case for the swaps
    send_set('{32'd3, 32'd2, 32'd1, 32'd0, 32'hffff_ffff});
    send_set('{32'h8000_0001, 32'h7fff_fffe});
    wait_drained();
    vals = {};
    for (int k = 0; k < 3; k++) begin
      vals.push_back(32'hffff_0000 ^ (32'h1 << (k * 11)));
    end
    send_set(vals);
    wait_drained();
  endtask

  task automatic test_store_full();
    sse_pkg::word_t vals[$];
    // exactly full: nothing dropped
    vals = {};
    for (int k = 0; k < sse_pkg::MAX_ENTRIES; k++) begin
      vals.push_back(pick_value());
    end
    send_set(vals);
    wait_drained();
    // overflow, with the closing item itself discarded
    vals = {};
    for (int k = 0; k < sse_pkg::MAX_ENTRIES + 2; k++) begin
      vals.push_back(pick_value());
    end
    send_set(vals);
    wait_drained();
    // next set after an overflow starts clean
    send_set('{32'd9, 32'd7});
    wait_drained();
  endtask

  task automatic test_random_sets(input int send_pct, input int recv_pct, input int items);
    sse_pkg::word_t vals[$];
    int    sent;
    int    size_sel;
    int    set_size;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < items) begin
      size_sel = $urandom_range(99);
      if (size_sel < 85) begin
        set_size = $urandom_range(8, 1);
      end else if (size_sel < 96) begin
        set_size = $urandom_range(20, 9);
      end else begin
        set_size = $urandom_range(sse_pkg::MAX_ENTRIES + 6, sse_pkg::MAX_ENTRIES - 4);
      end
      vals = {};
      for (int k = 0; k < set_size; k++) begin
        vals.push_back(pick_value());
      end
      send_set(vals);
      sent += set_size;
      if ($urandom_range(9) == 0) begin
        wait_drained();
      end
    end
    wait_drained();
  endtask

  // Receiver: drop ready at random; decided at the falling edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    sorted_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (sorted_expect.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected result: value=%0d last=%0b dropped=%0b",
                   $signed(out_tdata), out_tlast, out_tuser[0]);
        end
      end else begin
        want = sorted_expect.pop_front();
        if (out_tdata !== want.value || out_tlast !== want.last ||
            out_tuser[0] !== want.dropped) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch: value exp=%0d got=%0d last exp=%0b got=%0b",
                     $signed(want.value), $signed(out_tdata), want.last, out_tlast,
                     " dropped exp=%0b got=%0b", want.dropped, out_tuser[0]);
          end
        end
      end
    end
  end

  // Watchdog: count cycles with no request accepted on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_tvalid        = 1'b0;
    in_tdata         = '0;
    in_tlast         = 1'b0;
    send_idle_pct    = 18;
    recv_idle_pct    = 74;
    pending_overflow = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_values();
    test_store_full();
    test_random_sets(18, 74, 8);
    test_random_sets(74, 18, 8);
    test_random_sets(0, 0, 8);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && sorted_expect.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
